// ----- hdl/rtcw_pkg.sv -----
`default_nettype none

package rtcw_pkg;

    // Stream payload widths, padded to whole bytes.
    localparam int unsigned InDataW  = 40;
    localparam int unsigned OutDataW = 48;

    // Calendar limits.
    localparam logic [11:0] YearMin   = 12'd1970;
    localparam logic [11:0] YearMax   = 12'd2099;
    localparam logic [11:0] YearSat   = 12'd4095;
    localparam logic [3:0]  MonthMax  = 4'd12;
    localparam logic [4:0]  HoursMax  = 5'd23;
    localparam logic [5:0]  MinSecMax = 6'd59;
    localparam logic [2:0]  Sunday    = 3'd7;
    localparam logic [2:0]  Monday    = 3'd1;

    // Reset value of the prescaler register.
    localparam logic [7:0] TicksReset = 8'd8;

    // Command codes carried in the input tuser.
    typedef enum logic [1:0] {
        CMD_TICK = 2'd0,
        CMD_SET  = 2'd1,
        CMD_READ = 2'd2
    } t_cmd;

    // Broken-down time of day and date.
    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [2:0]  weekday;
        logic [4:0]  hours;
        logic [5:0]  minutes;
        logic [5:0]  seconds;
    } t_time;

    // 1970-01-01 00:00:00, a Thursday.
    localparam t_time TimeReset = '{
        year:    12'd1970,
        month:   4'd1,
        day:     5'd1,
        weekday: 3'd4,
        hours:   5'd0,
        minutes: 6'd0,
        seconds: 6'd0
    };

    // Number of days in a month; zero for a month code outside 1 to 12.
    function automatic logic [4:0] month_len(input logic leap, input logic [3:0] month);
        logic [4:0] len;
        unique case (month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    // Month term of the weekday formula, with March as the first month.
    function automatic logic [4:0] month_offset(input logic [3:0] month);
        logic [4:0] ofs;
        unique case (month)
            4'd3:    ofs = 5'd2;
            4'd4:    ofs = 5'd5;
            4'd5:    ofs = 5'd7;
            4'd6:    ofs = 5'd10;
            4'd7:    ofs = 5'd12;
            4'd8:    ofs = 5'd15;
            4'd9:    ofs = 5'd18;
            4'd10:   ofs = 5'd20;
            4'd11:   ofs = 5'd23;
            4'd12:   ofs = 5'd25;
            4'd1:    ofs = 5'd28;
            4'd2:    ofs = 5'd31;
            default: ofs = 5'd0;
        endcase
        return ofs;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/rtcw_calc.sv -----
`default_nettype none

module rtcw_calc (
    input  rtcw_pkg::t_cmd  i_cmd,
    input  rtcw_pkg::t_time i_set,
    input  rtcw_pkg::t_time i_cur,
    input  logic [7:0]      i_sub,
    input  logic [7:0]      i_tps,
    output rtcw_pkg::t_time o_next,
    output logic [7:0]      o_sub_next,
    output logic            o_status
);
    import rtcw_pkg::*;

    // Gregorian leap year of the running year, which may reach 4095.
    // year / 100 by reciprocal multiplication, exact below 4096.
    logic [22:0] cur_prod100;
    logic [5:0]  cur_q100;
    logic [11:0] cur_r100;
    logic        cur_leap;
    logic [4:0]  cur_mlen;

    assign cur_prod100 = 23'(i_cur.year) * 23'd1311;
    assign cur_q100    = cur_prod100[22:17];
    assign cur_r100    = i_cur.year - (12'(cur_q100) * 12'd100);
    assign cur_leap    = (i_cur.year[1:0] == 2'b00) &&
                         ((cur_r100 != 12'd0) || (cur_q100[1:0] == 2'b00));
    assign cur_mlen    = month_len(cur_leap, i_cur.month);

    // Validity of a set. Within 1970 to 2099 every fourth year is a leap year.
    logic set_leap;
    logic set_ok;

    assign set_leap = (i_set.year[1:0] == 2'b00);
    assign set_ok   = (i_set.year >= YearMin) && (i_set.year <= YearMax) &&
                      (i_set.month >= 4'd1) && (i_set.month <= MonthMax) &&
                      (i_set.day >= 5'd1) &&
                      (i_set.day <= month_len(set_leap, i_set.month)) &&
                      (i_set.hours <= HoursMax) &&
                      (i_set.minutes <= MinSecMax) && (i_set.seconds <= MinSecMax);

    // Weekday of the set date. For the years that pass the check, the
    // century terms -y/100 + y/400 always come to -15.
    logic        early;
    logic [11:0] wy;
    logic [11:0] wsum;
    logic [25:0] prod7;
    logic [9:0]  q7;
    logic [2:0]  r7;
    logic [2:0]  set_weekday;

    assign early       = (i_set.month <= 4'd2);
    assign wy          = i_set.year - 12'(early);
    assign wsum        = 12'(i_set.day) + 12'(month_offset(i_set.month)) + wy +
                         (wy >> 2) - 12'd15;
    assign prod7       = 26'(wsum) * 26'd9363;
    assign q7          = prod7[25:16];
    assign r7          = 3'(wsum - (12'(q7) * 12'd7));
    assign set_weekday = (r7 == 3'd0) ? Sunday : r7;

    // Carry chain from seconds up to the year.
    logic [6:0] sec1;
    logic [6:0] min1;
    logic [5:0] hr1;
    logic [3:0] wd1;
    logic [5:0] day1;
    logic [4:0] mon1;
    t_time      adv;

    always_comb begin
        sec1 = {1'b0, i_cur.seconds} + 7'd1;
        min1 = {1'b0, i_cur.minutes} + 7'd1;
        hr1  = {1'b0, i_cur.hours} + 6'd1;
        wd1  = {1'b0, i_cur.weekday} + 4'd1;
        day1 = {1'b0, i_cur.day} + 6'd1;
        mon1 = {1'b0, i_cur.month} + 5'd1;
        adv  = i_cur;
        if (sec1 < 7'd60) begin
            adv.seconds = sec1[5:0];
        end else begin
            adv.seconds = 6'd0;
            if (min1 < 7'd60) begin
                adv.minutes = min1[5:0];
            end else begin
                adv.minutes = 6'd0;
                if (hr1 < 6'd24) begin
                    adv.hours = hr1[4:0];
                end else begin
                    adv.hours   = 5'd0;
                    adv.weekday = (wd1 >= 4'd8) ? Monday : wd1[2:0];
                    if (day1 <= {1'b0, cur_mlen}) begin
                        adv.day = day1[4:0];
                    end else begin
                        adv.day = 5'd1;
                        if (mon1 > {1'b0, MonthMax}) begin
                            adv.month = 4'd1;
                            if (i_cur.year < YearSat) begin
                                adv.year = i_cur.year + 12'd1;
                            end
                        end else begin
                            adv.month = mon1[3:0];
                        end
                    end
                end
            end
        end
    end

    // Command decode.
    logic [7:0] sub_inc;

    assign sub_inc = i_sub + 8'd1;

    always_comb begin
        o_next     = i_cur;
        o_sub_next = i_sub;
        o_status   = 1'b0;
        unique case (i_cmd)
            CMD_TICK: begin
                if (sub_inc == i_tps) begin
                    o_sub_next = 8'd0;
                    o_next     = adv;
                end else begin
                    o_sub_next = sub_inc;
                end
            end
            CMD_SET: begin
                if (set_ok) begin
                    o_next         = i_set;
                    o_next.weekday = set_weekday;
                end else begin
                    o_status = 1'b1;
                end
            end
            default: begin
                // A read, or the unused code, leaves everything as it is.
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- hdl/calendar_clock_with_weekday_unit.sv -----
// An accepted command is captured in the input register; its result is then
// captured in the result register and offered on the result stream.
// Throughput: one command per cycle unless the result stream stalls; the
// carry chain and weekday computation sit between input and result register.
// Reset (synchronous, active low): 1970-01-01 00:00:00, Thursday, prescaler
// count cleared, ticks per second set to 8, both pipeline stages empty.
`default_nettype none

module calendar_clock_with_weekday_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Command stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [11:0] set_year, [15:12] set_month, [20:16] set_day, [25:21] set_hours,
    // [31:26] set_minutes, [37:32] set_seconds, [39:38] zero
    input  logic [rtcw_pkg::InDataW-1:0]  s_axis_tdata,
    // [1:0] command
    input  logic [1:0]  s_axis_tuser,
    // Result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [11:0] cur_year, [15:12] cur_month, [20:16] cur_day, [23:21] cur_weekday,
    // [28:24] cur_hours, [34:29] cur_minutes, [40:35] cur_seconds, [47:41] zero
    output logic [rtcw_pkg::OutDataW-1:0] m_axis_tdata,
    // [0] status
    output logic        m_axis_tuser
);
    import rtcw_pkg::*;

    // Prescaler register, written by a completed APB write to the first word.
    logic [7:0] r_tps;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
    assign prdata = (paddr[2] == 1'b0) ? {24'd0, r_tps} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tps <= TicksReset;
        end else if (cfg_wr) begin
            r_tps <= pwdata[7:0];
        end
    end

    // Pipeline handshake: the result stage moves when empty or drained, and
    // the input stage takes a new transaction when it is empty or moving on.
    logic r_in_valid;
    logic r_out_valid;
    logic out_adv;
    logic in_take;

    assign out_adv       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || out_adv;
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;

    // Input register.
    t_cmd  r_cmd;
    t_time r_set;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_cmd         <= t_cmd'(s_axis_tuser);
            r_set.year    <= s_axis_tdata[11:0];
            r_set.month   <= s_axis_tdata[15:12];
            r_set.day     <= s_axis_tdata[20:16];
            r_set.weekday <= 3'd0;
            r_set.hours   <= s_axis_tdata[25:21];
            r_set.minutes <= s_axis_tdata[31:26];
            r_set.seconds <= s_axis_tdata[37:32];
        end
    end

    // Next time and prescaler count for the command in the input register.
    t_time      n_time;
    logic [7:0] n_sub;
    logic       n_status;
    t_time      r_time;
    logic [7:0] r_sub;

    rtcw_calc u_calc (
        .i_cmd      (r_cmd),
        .i_set      (r_set),
        .i_cur      (r_time),
        .i_sub      (r_sub),
        .i_tps      (r_tps),
        .o_next     (n_time),
        .o_sub_next (n_sub),
        .o_status   (n_status)
    );

    // Clock state and result register, both updated as a command completes.
    logic  step;
    t_time r_out_time;
    logic  r_out_status;

    assign step = r_in_valid && out_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time      <= TimeReset;
            r_sub       <= 8'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (step) begin
                r_time <= n_time;
                r_sub  <= n_sub;
            end
            if (out_adv) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_time   <= n_time;
            r_out_status <= n_status;
        end
    end

    // Result packing.
    assign m_axis_tuser = r_out_status;
    assign m_axis_tdata = {7'd0,
                           r_out_time.seconds,
                           r_out_time.minutes,
                           r_out_time.hours,
                           r_out_time.weekday,
                           r_out_time.day,
                           r_out_time.month,
                           r_out_time.year};

    logic unused_cfg;
    assign unused_cfg = ^{paddr[1:0], pwdata[31:8], s_axis_tdata[39:38]};

endmodule

`default_nettype wire
